### rtl/cie1931_color_matching_lerp_unit_assert.svh
// assertion macros shared by the checker
`ifndef CIE1931_COLOR_MATCHING_LERP_UNIT_ASSERT_SVH
`define CIE1931_COLOR_MATCHING_LERP_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CML_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define CML_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/cml_pkg.sv
// shared constants, tables and stage types for the color matching unit
`default_nettype none
package cml_pkg;
    localparam int STORED_SAMPLES = 81;
    localparam int START_STEP = 76;
    localparam int STEP_UNITS = 80;
    localparam int WL_W = 14;
    localparam int IDX_W = 8;
    localparam int R_W = 7;
    localparam int OUT_W = 17;
    localparam int MICRO_W = 21;

    typedef logic [MICRO_W-1:0] micro_t;

    function automatic micro_t x_micro(input int i);
        micro_t t [0:STORED_SAMPLES-1];
        t = '{
            1368, 2236, 4243, 7650, 14310, 23190, 43510, 77630, 134380, 214770,
            283900, 328500, 348280, 348060, 336200, 318700, 290800, 251100, 195360,
            142100, 95640, 57950, 32010, 14700, 4900, 2400, 9300, 29100, 63270,
            109600, 165500, 225750, 290400, 359700, 433450, 512050, 594500, 678400,
            762100, 842500, 916300, 978600, 1026300, 1056700, 1062200, 1045600,
            1002600, 938400, 854450, 751400, 642400, 541900, 447900, 360800, 283500,
            218700, 164900, 121200, 87400, 63600, 46770, 32900, 22700, 15840, 11359,
            8111, 5790, 4109, 2899, 2049, 1440, 1000, 690, 476, 332, 235, 166, 117,
            83, 59, 42};
        return t[i];
    endfunction

    function automatic micro_t y_micro(input int i);
        micro_t t [0:STORED_SAMPLES-1];
        t = '{
            39, 64, 120, 217, 396, 640, 1210, 2180, 4000, 7300, 11600, 16840, 23000,
            29800, 38000, 48000, 60000, 73900, 90980, 112600, 139020, 169300, 208020,
            258600, 323000, 407300, 503000, 608200, 710000, 793200, 862000, 914850,
            954000, 980300, 994950, 1000000, 995000, 978600, 952000, 915400, 870000,
            816300, 757000, 694900, 631000, 566800, 503000, 441200, 381000, 321000,
            265000, 217000, 175000, 138200, 107000, 81600, 61000, 44580, 32000, 23200,
            17000, 11920, 8210, 5723, 4102, 2929, 2091, 1484, 1047, 740, 520, 361,
            249, 172, 120, 85, 60, 42, 30, 21, 15};
        return t[i];
    endfunction

    function automatic micro_t z_micro(input int i);
        micro_t t [0:STORED_SAMPLES-1];
        t = '{
            6450, 10550, 20050, 36210, 67850, 110200, 207400, 371300, 645600,
            1039050, 1385600, 1622960, 1747060, 1782600, 1772110, 1744100, 1669200,
            1528100, 1287640, 1041900, 812950, 616200, 465180, 353300, 272000,
            212300, 158200, 111700, 78250, 57250, 42160, 29840, 20300, 13400, 8750,
            5750, 3900, 2750, 2100, 1800, 1650, 1400, 1100, 1000, 800, 600, 340, 240,
            190, 100, 50, 30, 20, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
            0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        return t[i];
    endfunction

    // index and remainder of a wavelength, by 1/80 = 1/16 * 1/5
    typedef struct packed {
        logic               in_range;
        logic               below;   // index -1: a is zero
        logic [IDX_W-1:0]   idx;     // index of a (or of b when below)
        logic [R_W-1:0]     rem;
    } cml_addr_t;
endpackage
`default_nettype wire

### rtl/cml_addr.sv
// stage 1: split the wavelength into table index and remainder
`default_nettype none
module cml_addr #(
    parameter int TABLE_ENTRIES = 81
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [cml_pkg::WL_W-1:0] wl,
    output cml_pkg::cml_addr_t        addr_reg
);
    import cml_pkg::*;
    logic [WL_W-5:0] q16;
    logic [3:0]      r16;
    logic [WL_W-5:0] q80;
    logic [R_W-1:0]  rem;
    logic [WL_W-4:0] step;   // one sign-free offset: step = q80 - START_STEP + 1
    cml_addr_t       addr_next;

    always_comb begin
        q16 = wl[WL_W-1:4];
        r16 = wl[3:0];
        // q16 < 1024: q16/5 by reciprocal 205/1024 is exact in this range
        q80 = (WL_W-4)'(({8'd0, q16} * 18'd205) >> 10);
        rem = R_W'({q16 - WL_W'(q80 * 3'd5), 4'b0000}) + R_W'(r16);
        step = {1'b0, q80} + 11'd1 - 11'(START_STEP);
        addr_next.rem = rem;
        addr_next.below = (step == '0);
        addr_next.in_range = ({1'b0, q80} + 11'd1 >= 11'(START_STEP))
            && (32'(step) <= TABLE_ENTRIES);
        addr_next.idx = addr_next.below ? '0 : IDX_W'(step - 11'd1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            addr_reg <= addr_next;
        end
    end
endmodule
`default_nettype wire

### rtl/cml_lerp.sv
// one channel: table lookup, weight multiply and divide by the step
`default_nettype none
module cml_lerp #(
    parameter int TABLE_ENTRIES = 81,
    parameter int OUTPUT_FRAC_BITS = 16,
    parameter int CHAN = 0
) (
    input  wire logic                    aclk,
    input  wire logic                    en2,
    input  wire logic                    en3,
    input  wire logic                    en4,
    input  wire cml_pkg::cml_addr_t      addr,
    output logic [cml_pkg::OUT_W-1:0]    value_reg
);
    import cml_pkg::*;
    localparam int EW = OUTPUT_FRAC_BITS + 2;     // entry width
    localparam int SW = EW + R_W;                 // weighted sum width
    localparam int XW = SW - 4;                   // sum with the /16 part dropped
    // ceil(2^SW / 5): x * RECIP >> SW is floor(x/5) for every x below 2^XW
    localparam logic [SW-1:0] RECIP = SW'(((64'd1 << SW) + 64'd4) / 64'd5);

    function automatic logic [EW-1:0] entry(input int i);
        logic [63:0] v;
        micro_t m;
        if (i < 0 || i >= TABLE_ENTRIES || i >= STORED_SAMPLES) begin
            return '0;
        end
        m = (CHAN == 0) ? x_micro(i) : (CHAN == 1) ? y_micro(i) : z_micro(i);
        v = ((64'(m) << OUTPUT_FRAC_BITS) + 64'd500000) / 64'd1000000;
        return EW'(v);
    endfunction

    logic [EW-1:0]  a_reg, a_next, b_reg, b_next;
    logic [R_W-1:0] r_reg;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [XW+SW-1:0] prod;
    logic [SW-1:0]  q;

    always_comb begin
        a_next = '0;
        b_next = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (addr.in_range && 32'(addr.idx) == i) begin
                a_next = addr.below ? '0 : entry(i);
                b_next = addr.below ? entry(i) : entry(i + 1);
            end
        end
        sum_next = SW'(a_reg) * SW'(7'd80 - r_reg) + SW'(b_reg) * SW'(r_reg);
        // floor(s/80) = floor((s >> 4) / 5), by reciprocal
        prod = (XW+SW)'(sum_reg[SW-1:4]) * (XW+SW)'(RECIP);
        q = SW'(prod >> SW);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            a_reg <= a_next;
            b_reg <= b_next;
            r_reg <= addr.rem;
        end
        if (en3) begin
            sum_reg <= sum_next;
        end
        if (en4) begin
            value_reg <= (q > SW'({OUT_W{1'b1}})) ? '1 : OUT_W'(q);
        end
    end
endmodule
`default_nettype wire

### rtl/cie1931_color_matching_lerp_unit.sv
// channel     | signals                                   | handshake
// s (input)   | s_wavelength[13:0]                        | s_valid / s_ready
// m (result)  | m_tristimulus_x/y/z[16:0]                 | m_valid / m_ready
// four register stages: index split, table read, weighted sum, divide by 80
// one item per cycle unless m stalls; a transfer passes the index, table, sum and divide registers to m_valid
// aresetn clears only the stage valid bits
// a stage advances when it is empty or the one after it advances, so a stall on m
// holds a stage only when all stages after it are full, and s_ready drops only when full
`default_nettype none
module cie1931_color_matching_lerp_unit #(
    parameter int TABLE_ENTRIES = 81,
    parameter int OUTPUT_FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [13:0]  s_wavelength,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [16:0]       m_tristimulus_x,
    output logic [16:0]       m_tristimulus_y,
    output logic [16:0]       m_tristimulus_z
);
    import cml_pkg::*;
    logic [3:0] vld_reg, vld_next;
    logic [3:0] en;
    cml_addr_t  addr;

    always_comb begin
        en[3] = !vld_reg[3] || m_ready;
        en[2] = !vld_reg[2] || en[3];
        en[1] = !vld_reg[1] || en[2];
        en[0] = !vld_reg[0] || en[1];
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        vld_next[1] = en[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en[3] ? vld_reg[2] : vld_reg[3];
    end
    assign s_ready = en[0];
    assign m_valid = vld_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    cml_addr #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_addr (
        .aclk(aclk), .en(en[0] && s_valid), .wl(s_wavelength), .addr_reg(addr)
    );
    cml_lerp #(.TABLE_ENTRIES(TABLE_ENTRIES), .OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS),
        .CHAN(0)) u_x (.aclk(aclk), .en2(en[1]), .en3(en[2]), .en4(en[3]),
        .addr(addr), .value_reg(m_tristimulus_x));
    cml_lerp #(.TABLE_ENTRIES(TABLE_ENTRIES), .OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS),
        .CHAN(1)) u_y (.aclk(aclk), .en2(en[1]), .en3(en[2]), .en4(en[3]),
        .addr(addr), .value_reg(m_tristimulus_y));
    cml_lerp #(.TABLE_ENTRIES(TABLE_ENTRIES), .OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS),
        .CHAN(2)) u_z (.aclk(aclk), .en2(en[1]), .en3(en[2]), .en4(en[3]),
        .addr(addr), .value_reg(m_tristimulus_z));
endmodule
`default_nettype wire

### rtl/cml_checker.sv
// port-level checker for the color matching unit, bound to the top level
`default_nettype none
`include "cie1931_color_matching_lerp_unit_assert.svh"
module cml_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [16:0] m_tristimulus_x
);
    // a result waiting on the output keeps its value
    `CML_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_tristimulus_x))
    // output free means input free
    `CML_ASSERT_IMP(a_flow, aclk, aresetn, m_ready, s_ready)
    // input held off only when a result is waiting on the output
    `CML_ASSERT_IMP(a_full, aclk, aresetn, s_valid && !s_ready, m_valid && !m_ready)
endmodule
bind cie1931_color_matching_lerp_unit cml_port_checker u_cml_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_tristimulus_x(m_tristimulus_x)
);
`default_nettype wire

### test/cml_checker.sv
// checker for the color matching unit: predicts x/y/z per transfer and compares
`default_nettype none
module cml_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [13:0] s_wavelength,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [16:0] m_tristimulus_x,
    input  wire logic [16:0] m_tristimulus_y,
    input  wire logic [16:0] m_tristimulus_z,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_CNT = 81;

    typedef struct packed {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
    } xyz_t;

    xyz_t xyz_q[$];
    int   err_cnt = 0;

    // sample in Q2.16 with round half up; zero outside the table
    function automatic longint sample_fixed(input int ch, input int i);
        longint m;
        if (i < 0 || i >= SAMPLE_CNT) return 0;
        unique case (ch)
            0: m = cml_pkg::x_micro(i);
            1: m = cml_pkg::y_micro(i);
            default: m = cml_pkg::z_micro(i);
        endcase
        return ((m << FRAC_BITS) + 500000) / 1000000;
    endfunction

    function automatic logic [16:0] interp(input int ch, input int i, input int r);
        longint v;
        v = (sample_fixed(ch, i) * (80 - r) + sample_fixed(ch, i + 1) * r) / 80;
        return (v > 131071) ? 17'h1ffff : v[16:0];
    endfunction

    function automatic xyz_t predict_xyz(input logic [13:0] wl);
        int   idx;
        int   r;
        xyz_t o;
        idx = int'(wl) / 80 - 76;
        r = int'(wl) % 80;
        o = '0;
        if (idx >= -1 && idx <= SAMPLE_CNT - 1) begin
            o.x = interp(0, idx, r);
            o.y = interp(1, idx, r);
            o.z = interp(2, idx, r);
        end
        return o;
    endfunction

    assign fail_count = err_cnt;
    assign pending_count = xyz_q.size();

    always @(posedge aclk) begin
        xyz_t e;
        if (aresetn) begin
            if (s_valid && s_ready) xyz_q.push_back(predict_xyz(s_wavelength));
            if (m_valid && m_ready) begin
                if (xyz_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_cnt++;
                end else begin
                    e = xyz_q.pop_front();
                    if (m_tristimulus_x !== e.x) begin
                        $error("tristimulus_x expected %0d actual %0d", e.x, m_tristimulus_x);
                        err_cnt++;
                    end
                    if (m_tristimulus_y !== e.y) begin
                        $error("tristimulus_y expected %0d actual %0d", e.y, m_tristimulus_y);
                        err_cnt++;
                    end
                    if (m_tristimulus_z !== e.z) begin
                        $error("tristimulus_z expected %0d actual %0d", e.z, m_tristimulus_z);
                        err_cnt++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### test/tb.sv
// top of the color matching unit testbench: stimulus, flow control and verdict
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [13:0] s_wavelength;
    logic        m_valid;
    logic        m_ready;
    logic [16:0] m_tristimulus_x;
    logic [16:0] m_tristimulus_y;
    logic [16:0] m_tristimulus_z;
    int          fail_count;
    int          pending_count;
    int          idle_pct;
    int          stall_pct;
    int          hold_cycles;
    int          cycle_cnt;
    int          sent_cnt;

    cie1931_color_matching_lerp_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_wavelength(s_wavelength),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tristimulus_x(m_tristimulus_x), .m_tristimulus_y(m_tristimulus_y),
        .m_tristimulus_z(m_tristimulus_z)
    );

    cml_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_wavelength(s_wavelength),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tristimulus_x(m_tristimulus_x), .m_tristimulus_y(m_tristimulus_y),
        .m_tristimulus_z(m_tristimulus_z),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt > 200000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // one transfer, with random idle cycles ahead of it
    task automatic send_wavelength(input logic [13:0] wl);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_wavelength <= wl;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
    endtask

    // lower s_valid and wait for the clock first so the checker has logged the last transfer
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // mostly inside the table and its ramps, some anywhere in range
    function automatic logic [13:0] pick_wavelength();
        int k;
        k = $urandom_range(99);
        if (k < 75) return 14'($urandom_range(6000, 12639));
        if (k < 85) return 14'($urandom_range(5999, 6080)) | 14'd0;
        if (k < 92) return 14'($urandom_range(12480, 12640));
        return 14'($urandom);
    endfunction

    initial begin
        logic [13:0] directed [$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_wavelength = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        sent_cnt = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes, below-table ramp, table edges, last entry ramp, beyond
        directed = '{14'd0, 14'd16383, 14'd5999, 14'd6000, 14'd6001, 14'd6040, 14'd6079,
                     14'd6080, 14'd6081, 14'd6159, 14'd6160, 14'd7120, 14'd7121,
                     14'd8880, 14'd9123, 14'd12399, 14'd12400, 14'd12401, 14'd12479,
                     14'd12480, 14'd12481, 14'd12559, 14'd12560, 14'd12561, 14'd10922};
        foreach (directed[i]) send_wavelength(directed[i]);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            if (phase == 2) hold_cycles = 60;
            for (int n = 0; n < 270; n++) send_wavelength(pick_wavelength());
            // sender pauses until all results are back
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("covered %0d wavelengths: table body, both edge ramps, out of range,", sent_cnt);
        $display("with sender gaps, receiver stalls and a long output hold-off");
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
